// File: rtl/core/mpgsp_pkg.sv
// Shared definitions for the multi-port gate and strobe pulser.
// Holds request codes, field widths and the strobe width table; no dependencies.
package mpgsp_pkg;

    // Widths of the item fields and internal state.
    localparam int REQ_W     = 2;
    localparam int PORT_W    = 3;
    localparam int WIDX_W    = 3;
    localparam int CNT_W     = 5;
    localparam int OUT_W     = 8;
    localparam int LINES_MAX = 8;

    // Default number of output lines.
    localparam int NUM_LINES_DEFAULT = 8;

    // Number of legal strobe width selections.
    localparam logic [WIDX_W-1:0] WIDX_COUNT = WIDX_W'(5);

    // Request codes carried in req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_GATE   = 2'd1,
        REQ_STROBE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Strobe length in ticks for a width selection: five ticks per step.
    function automatic logic [CNT_W-1:0] width_ticks(input logic [WIDX_W-1:0] idx);
        logic [CNT_W-1:0] ticks;
        case (idx)
            3'd0:    ticks = 5'd5;
            3'd1:    ticks = 5'd10;
            3'd2:    ticks = 5'd15;
            3'd3:    ticks = 5'd20;
            3'd4:    ticks = 5'd25;
            default: ticks = 5'd5;
        endcase
        return ticks;
    endfunction

endpackage

// File: rtl/core/multi_port_gate_strobe_pulser_unit.sv
// Top level of the multi-port gate and strobe pulser.
// Depends on mpgsp_pkg for request codes, widths and the strobe width table.

// The block drives a bank of NUM_LINES sync output lines. Each input beat is a
// tick, a gate write or a strobe start; every beat returns exactly one result
// beat carrying the latched line levels and the strobe marks as they stand
// after that beat. A gate beat sets or clears one line's pending level. A
// strobe beat raises the pending level, marks the line as strobing and loads
// its countdown with 5, 10, 15, 20 or 25 ticks, chosen by the width register.
// A tick beat copies the pending levels to the output latch, so the visible
// outputs trail the pending levels by one tick, and then counts down every
// strobing line; a count that reaches zero ends the strobe and drops the line.
// All lines update in parallel in the cycle the beat is accepted, so one beat
// is taken every clock cycle while in_stall is low; the result is registered.
// The result sits in an output register backed by one skid entry, so the input
// side keeps accepting while a result waits, and only stalls once both are
// full. Width register writes of 5 to 7 are ignored; gate or strobe beats
// aimed at a line at or above NUM_LINES, and beats with an unknown request
// code, change nothing and simply report the current state. Result bits for
// lines at or above NUM_LINES always read as zero.
module multi_port_gate_strobe_pulser_unit
    import mpgsp_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Strobe width register write port.
    input  logic              cfg_wr_en,
    input  logic [WIDX_W-1:0] cfg_wr_data,

    // Input channel.
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [PORT_W-1:0] port_index,
    input  logic              gate_level,

    // Result channel.
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  line_outputs,
    output logic [OUT_W-1:0]  strobes_active
);

    // Line state.
    logic [NUM_LINES-1:0] pending_reg,  pending_next;
    logic [NUM_LINES-1:0] latched_reg,  latched_next;
    logic [NUM_LINES-1:0] marks_reg,    marks_next;
    logic [CNT_W-1:0]     count_reg  [NUM_LINES];
    logic [CNT_W-1:0]     count_next [NUM_LINES];
    logic [WIDX_W-1:0]    widx_reg,     widx_next;

    // Output register and skid entry.
    logic                 out_valid_reg,  out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0]     out_lines_reg,  out_lines_next;
    logic [OUT_W-1:0]     out_marks_reg,  out_marks_next;
    logic [OUT_W-1:0]     skid_lines_reg, skid_lines_next;
    logic [OUT_W-1:0]     skid_marks_reg, skid_marks_next;

    logic                 in_accept;
    logic                 out_take;
    logic                 port_ok;
    logic [NUM_LINES-1:0] line_sel;
    logic [CNT_W-1:0]     load_ticks;
    logic [OUT_W-1:0]     res_lines;
    logic [OUT_W-1:0]     res_marks;
    req_t                 req;

    // The input side stalls only while the skid entry holds a result.
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    assign out_valid      = out_valid_reg;
    assign line_outputs   = out_lines_reg;
    assign strobes_active = out_marks_reg;

    assign req        = req_t'(req_type);
    assign port_ok    = {1'b0, port_index} < (PORT_W + 1)'(NUM_LINES);
    assign load_ticks = width_ticks(widx_reg);

    // Out-of-range selections leave the width register as it was.
    always_comb
    begin
        widx_next = widx_reg;
        if (cfg_wr_en && (cfg_wr_data < WIDX_COUNT))
        begin
            widx_next = cfg_wr_data;
        end
    end

    // One-hot select of the addressed line.
    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            line_sel[i] = port_ok && (port_index == PORT_W'(i));
        end
    end

    // Line update for the accepted beat; every line works in parallel.
    always_comb
    begin
        pending_next = pending_reg;
        latched_next = latched_reg;
        marks_next   = marks_reg;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            count_next[i] = count_reg[i];
        end

        if (in_accept)
        begin
            case (req)
                REQ_TICK:
                begin
                    latched_next = pending_reg;
                    for (int i = 0; i < NUM_LINES; i++)
                    begin
                        if (marks_reg[i])
                        begin
                            // A count of zero or one finishes the strobe now.
                            if (count_reg[i] <= CNT_W'(1))
                            begin
                                count_next[i]   = '0;
                                marks_next[i]   = 1'b0;
                                pending_next[i] = 1'b0;
                            end
                            else
                            begin
                                count_next[i] = count_reg[i] - CNT_W'(1);
                            end
                        end
                    end
                end
                REQ_GATE:
                begin
                    for (int i = 0; i < NUM_LINES; i++)
                    begin
                        if (line_sel[i])
                        begin
                            pending_next[i] = gate_level;
                        end
                    end
                end
                REQ_STROBE:
                begin
                    for (int i = 0; i < NUM_LINES; i++)
                    begin
                        if (line_sel[i])
                        begin
                            pending_next[i] = 1'b1;
                            marks_next[i]   = 1'b1;
                            count_next[i]   = load_ticks;
                        end
                    end
                end
                default:
                begin
                    // Unknown request: state is left alone.
                end
            endcase
        end
    end

    // Result of the beat, widened to the output field with unused lines zero.
    always_comb
    begin
        res_lines                = '0;
        res_marks                = '0;
        res_lines[NUM_LINES-1:0] = latched_next;
        res_marks[NUM_LINES-1:0] = marks_next;
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_lines_next  = out_lines_reg;
        out_marks_next  = out_marks_reg;
        skid_lines_next = skid_lines_reg;
        skid_marks_next = skid_marks_reg;

        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_lines_next  = skid_lines_reg;
                out_marks_next  = skid_marks_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_lines_next = res_lines;
                out_marks_next = res_marks;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_lines_next = res_lines;
                skid_marks_next = res_marks;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and line state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            latched_reg    <= '0;
            marks_reg      <= '0;
            widx_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            pending_reg    <= pending_next;
            latched_reg    <= latched_next;
            marks_reg      <= marks_next;
            widx_reg       <= widx_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_lines_reg  <= out_lines_next;
        out_marks_reg  <= out_marks_next;
        skid_lines_reg <= skid_lines_next;
        skid_marks_reg <= skid_marks_next;
    end

endmodule

// File: rtl/core/mpgsp_checker.sv
// Port-level checker for the multi-port gate and strobe pulser, with its bind.
// Depends on mpgsp_pkg for field widths.
module mpgsp_checker
    import mpgsp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [OUT_W-1:0] line_outputs,
    input logic [OUT_W-1:0] strobes_active
);

    // Every accepted beat leaves a result waiting on the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted beat produced no result");

    // The input side only stalls behind a result that is itself held up.
    a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // With nothing waiting at the output there is room for a new beat.
    a_empty_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

    // A held result keeps its payload.
    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(line_outputs) && $stable(strobes_active)))
        else $error("held result changed");

endmodule

bind multi_port_gate_strobe_pulser_unit mpgsp_checker u_mpgsp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .line_outputs   (line_outputs),
    .strobes_active (strobes_active)
);
